@@ design/lwf_pkg.sv @@
// Shared types, constants and the arctangent table for the wall-following controller.
// Used by lwf_cordic and lidar_wall_follow_pid; depends on nothing else.
`default_nettype none
package lwf_pkg;

  localparam int RANGE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;

  // datapath widths
  localparam int CW     = 44;  // CORDIC x and y
  localparam int ZW     = 34;  // CORDIC angle, Q2.30 with headroom
  localparam int STEP_W = 5;   // iteration index, covers TABLE_LEN

  localparam int INV_GAIN_Q15    = 19898;
  localparam int STEER_SCALE_Q32 = 59969056;
  localparam int S_CLAMP         = 8388608;
  localparam int BAND_HIGH       = 714;
  localparam int BAND_MID        = 1429;

  localparam logic [10:0] SPEED_HIGH = 11'd1500;
  localparam logic [10:0] SPEED_MID  = 11'd1000;
  localparam logic [10:0] SPEED_LOW  = 11'd500;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BEAM_COS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BEAM_SIN = 3'd6;

  typedef struct packed {
    logic [15:0] side_range_mm;
    logic [15:0] angled_range_mm;
  } in_t;

  typedef struct packed {
    logic signed [15:0] steer_angle;
    logic [10:0]        speed_mm_s;
    logic signed [15:0] wall_distance_mm;
  } out_t;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  // truncated atan(2^-i) in Q2.30
  function automatic logic [30:0] atan_q30(input logic [STEP_W-1:0] idx);
    logic [30:0] v;
    case (idx)
      5'd0:    v = 31'd843314856;
      5'd1:    v = 31'd497837829;
      5'd2:    v = 31'd263043836;
      5'd3:    v = 31'd133525158;
      5'd4:    v = 31'd67021686;
      5'd5:    v = 31'd33543515;
      5'd6:    v = 31'd16775850;
      5'd7:    v = 31'd8388437;
      5'd8:    v = 31'd4194282;
      5'd9:    v = 31'd2097149;
      5'd10:   v = 31'd1048575;
      5'd11:   v = 31'd524287;
      5'd12:   v = 31'd262143;
      5'd13:   v = 31'd131071;
      5'd14:   v = 31'd65535;
      5'd15:   v = 31'd32767;
      5'd16:   v = 31'd16383;
      5'd17:   v = 31'd8191;
      5'd18:   v = 31'd4095;
      5'd19:   v = 31'd2047;
      5'd20:   v = 31'd1023;
      5'd21:   v = 31'd511;
      5'd22:   v = 31'd255;
      5'd23:   v = 31'd127;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  // clip a range sample to the usable range width
  function automatic logic [15:0] range_sat(input logic [15:0] v);
    localparam int RANGE_MAX = (1 << RANGE_BITS) - 1;
    logic [15:0] r;
    r = v;
    if (RANGE_BITS < 16 && int'({16'd0, v}) > RANGE_MAX) r = 16'(RANGE_MAX);
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/lwf_cordic.sv @@
// Iterative CORDIC engine, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on lwf_pkg for widths, step count and the arctangent table.
`default_nettype none
module lwf_cordic (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lwf_pkg::cordic_ctl_t        ctl,
  input  wire logic signed [lwf_pkg::CW-1:0] x_in,
  input  wire logic signed [lwf_pkg::CW-1:0] y_in,
  input  wire logic signed [lwf_pkg::ZW-1:0] z_in,
  output logic                             done,
  output logic signed [lwf_pkg::CW-1:0]    x_out,
  output logic signed [lwf_pkg::ZW-1:0]    z_out
);

  logic signed [lwf_pkg::CW-1:0] x, y;
  logic signed [lwf_pkg::ZW-1:0] z;
  logic [lwf_pkg::STEP_W-1:0]    step;
  logic                          busy;
  logic                          vec;
  logic                          zero_vec;

  logic signed [lwf_pkg::CW-1:0] dx, dy, x_next, y_next;
  logic signed [lwf_pkg::ZW-1:0] at, z_next;
  logic                          neg;
  logic                          last;

  always_comb begin
    dx  = y >>> step;
    dy  = x >>> step;
    at  = $signed({{(lwf_pkg::ZW-31){1'b0}}, lwf_pkg::atan_q30(step)});
    neg = vec ? y[lwf_pkg::CW-1] : !z[lwf_pkg::ZW-1];
    if (neg) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - at;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + at;
    end
    last = (step == lwf_pkg::STEP_W'(lwf_pkg::CORDIC_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x        <= x_in;
      y        <= y_in;
      z        <= z_in;
      vec      <= ctl.vectoring;
      // a null vector has no angle: hold zero
      zero_vec <= ctl.vectoring && (x_in == '0) && (y_in == '0);
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      if (!zero_vec) z <= z_next;
    end
  end

  assign x_out = x;
  assign z_out = z;

endmodule
`default_nettype wire

@@ design/lidar_wall_follow_pid.sv @@
// Wall-following PID controller: top level with sequencer, shared multiplier and PID state.
// Depends on lwf_pkg and lwf_cordic.
//
// Use: each input word carries the side range and the angled range of one scan.
// A word is taken on in_valid && in_ready; in_ready is high only while the
// sequencer is idle. One result word (steering, speed band, projected wall
// distance) follows on out_valid/out_ready for every input word.
// From accept to out_valid: the multiplier states ST_M_AC, ST_M_AS, ST_M_BQ and
// ST_M_LQ, two CORDIC passes of CORDIC_STEPS iterations, each ending in its done
// strobe (the first pass overlaps ST_M_LQ), a launch state between the passes,
// and the states ST_ERR through ST_OUT for the error, PID terms and steering scale, all through
// one registered multiplier and one CORDIC stage reused every cycle.
// A new word is taken only back in the idle state, once the previous one has
// been through the whole sequence.
// The result sits in an output register; the next word is accepted while it
// waits. If the receiver still stalls when the next result is ready, the
// sequencer holds in its last state until the register frees.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write
// it only while idle, which the block itself does not enforce. Unknown indexes are
// ignored. Reset (rst, synchronous) restores the default gains and geometry, clears
// the integral and last error, and empties the output register.
`default_nettype none
module lidar_wall_follow_pid (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire lwf_pkg::in_t                    in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output lwf_pkg::out_t                        out_data,
  input  wire logic                            cfg_we,
  input  wire logic [lwf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [15:0]                     cfg_data
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_M_AC   = 4'd1;
  localparam logic [3:0] ST_M_AS   = 4'd2;
  localparam logic [3:0] ST_M_BQ   = 4'd3;
  localparam logic [3:0] ST_M_LQ   = 4'd4;
  localparam logic [3:0] ST_VWAIT  = 4'd5;
  localparam logic [3:0] ST_RSTART = 4'd6;
  localparam logic [3:0] ST_RWAIT  = 4'd7;
  localparam logic [3:0] ST_ERR    = 4'd8;
  localparam logic [3:0] ST_P_KP   = 4'd9;
  localparam logic [3:0] ST_P_KI   = 4'd10;
  localparam logic [3:0] ST_P_KD   = 4'd11;
  localparam logic [3:0] ST_SUM    = 4'd12;
  localparam logic [3:0] ST_P_ST   = 4'd13;
  localparam logic [3:0] ST_OUT    = 4'd14;

  localparam int CW = lwf_pkg::CW;
  localparam int ZW = lwf_pkg::ZW;

  localparam logic signed [CW-1:0] DIST_MAX = CW'(32767);
  localparam logic signed [CW-1:0] DIST_MIN = -CW'(32768);
  localparam logic signed [51:0]   S_MAX    = 52'(lwf_pkg::S_CLAMP);
  localparam logic signed [51:0]   S_MIN    = -52'(lwf_pkg::S_CLAMP);
  localparam logic signed [27:0]   STEER_MAX = 28'(32767);
  localparam logic signed [27:0]   STEER_MIN = -28'(32768);

  logic [3:0] state, state_next;

  // configuration
  logic [15:0] kp_gain, ki_gain, kd_gain, target_distance_mm, lookahead_mm;
  logic [14:0] beam_cos, beam_sin;

  // item data and intermediates
  logic [15:0]             b, a;
  logic signed [CW-1:0]    num, bq;
  logic signed [15:0]      wall_dist;
  logic signed [16:0]      err;
  logic signed [31:0]      sum;
  logic signed [17:0]      diff;
  logic signed [51:0]      acc;
  logic signed [24:0]      sneg;

  // PID state
  logic signed [16:0] last_error;
  logic signed [31:0] error_sum;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [59:0] p;
  logic               p_en;

  // CORDIC engine
  lwf_pkg::cordic_ctl_t   cordic_ctl;
  logic signed [CW-1:0]   cx_in, cy_in, cx_out;
  logic signed [ZW-1:0]   cz_in, cz_out;
  logic                   cordic_done;

  lwf_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cordic_ctl),
    .x_in  (cx_in),
    .y_in  (cy_in),
    .z_in  (cz_in),
    .done  (cordic_done),
    .x_out (cx_out),
    .z_out (cz_out)
  );

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain            <= 16'd2048;
      ki_gain            <= 16'd0;
      kd_gain            <= 16'd23;
      target_distance_mm <= 16'd950;
      lookahead_mm       <= 16'd500;
      beam_cos           <= 15'd21063;
      beam_sin           <= 15'd25102;
    end else if (cfg_we) begin
      case (cfg_index)
        lwf_pkg::REG_KP:       kp_gain            <= cfg_data;
        lwf_pkg::REG_KI:       ki_gain            <= cfg_data;
        lwf_pkg::REG_KD:       kd_gain            <= cfg_data;
        lwf_pkg::REG_TARGET:   target_distance_mm <= cfg_data;
        lwf_pkg::REG_LOOKAHD:  lookahead_mm       <= cfg_data;
        lwf_pkg::REG_BEAM_COS: beam_cos           <= cfg_data[14:0];
        lwf_pkg::REG_BEAM_SIN: beam_sin           <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    p_en  = 1'b1;
    case (state)
      ST_M_AC: begin
        mul_a = $signed({17'd0, a});
        mul_b = $signed({12'd0, beam_cos});
      end
      ST_M_AS: begin
        mul_a = $signed({17'd0, a});
        mul_b = $signed({12'd0, beam_sin});
      end
      ST_M_BQ: begin
        mul_a = $signed({17'd0, b});
        mul_b = 27'(lwf_pkg::INV_GAIN_Q15);
      end
      ST_M_LQ: begin
        mul_a = $signed({17'd0, lookahead_mm});
        mul_b = 27'(lwf_pkg::INV_GAIN_Q15);
      end
      ST_P_KP: begin
        mul_a = 33'(err);
        mul_b = $signed({11'd0, kp_gain});
      end
      ST_P_KI: begin
        mul_a = 33'(sum);
        mul_b = $signed({11'd0, ki_gain});
      end
      ST_P_KD: begin
        mul_a = 33'(diff);
        mul_b = $signed({11'd0, kd_gain});
      end
      ST_P_ST: begin
        mul_a = 33'(sneg);
        mul_b = 27'(lwf_pkg::STEER_SCALE_Q32);
      end
      default: p_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_en) p <= mul_a * mul_b;
  end

  // CORDIC launch
  logic signed [CW-1:0] p_cw;
  assign p_cw = p[CW-1:0];

  always_comb begin
    cordic_ctl.start     = 1'b0;
    cordic_ctl.vectoring = 1'b0;
    cx_in = bq;
    cy_in = p_cw;
    cz_in = -cz_out;
    case (state)
      ST_M_BQ: begin
        // p holds a*sin: that shifted is x, num is y
        cordic_ctl.start     = 1'b1;
        cordic_ctl.vectoring = 1'b1;
        cx_in = p_cw <<< 8;
        cy_in = num;
        cz_in = '0;
      end
      ST_RSTART: cordic_ctl.start = 1'b1;
      default: ;
    endcase
  end

  // error, integral, derivative
  logic signed [CW-1:0] d_round;
  logic signed [15:0]   wall_dist_next;
  logic signed [18:0]   e_wide;
  logic signed [16:0]   err_next;
  logic signed [32:0]   sum_wide;
  logic signed [31:0]   sum_next;
  logic signed [51:0]   s_full;
  logic signed [24:0]   s_sat;
  logic signed [59:0]   st_round;
  logic signed [27:0]   st_shift;
  logic signed [15:0]   steer;
  logic [16:0]          mag;
  logic [10:0]          speed;

  always_comb begin
    d_round = (cx_out + CW'(16384)) >>> 15;
    if (d_round > DIST_MAX)      wall_dist_next = 16'sd32767;
    else if (d_round < DIST_MIN) wall_dist_next = -16'sd32768;
    else                         wall_dist_next = d_round[15:0];

    e_wide = $signed({3'd0, target_distance_mm}) - 19'(wall_dist_next);
    if (e_wide > 19'sd65535)       err_next = 17'sd65535;
    else if (e_wide < -19'sd65536) err_next = -17'sd65536;
    else                           err_next = e_wide[16:0];

    sum_wide = 33'(error_sum) + 33'(err_next);
    if (sum_wide[32] != sum_wide[31])
      sum_next = sum_wide[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    else
      sum_next = sum_wide[31:0];

    s_full = acc + p[51:0];
    if (s_full > S_MAX)      s_sat = 25'(lwf_pkg::S_CLAMP);
    else if (s_full < S_MIN) s_sat = -25'(lwf_pkg::S_CLAMP);
    else                     s_sat = s_full[24:0];

    st_round = p + 60'sd2147483648;
    st_shift = st_round[59:32];
    if (st_shift > STEER_MAX)      steer = 16'sd32767;
    else if (st_shift < STEER_MIN) steer = -16'sd32768;
    else                           steer = st_shift[15:0];

    mag = steer[15] ? -17'(steer) : 17'(steer);
    if (mag <= 17'(lwf_pkg::BAND_HIGH))     speed = lwf_pkg::SPEED_HIGH;
    else if (mag <= 17'(lwf_pkg::BAND_MID)) speed = lwf_pkg::SPEED_MID;
    else                                    speed = lwf_pkg::SPEED_LOW;
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_M_AC;
      ST_M_AC:   state_next = ST_M_AS;
      ST_M_AS:   state_next = ST_M_BQ;
      ST_M_BQ:   state_next = ST_M_LQ;
      ST_M_LQ:   state_next = ST_VWAIT;
      ST_VWAIT:  if (cordic_done) state_next = ST_RSTART;
      ST_RSTART: state_next = ST_RWAIT;
      ST_RWAIT:  if (cordic_done) state_next = ST_ERR;
      ST_ERR:    state_next = ST_P_KP;
      ST_P_KP:   state_next = ST_P_KI;
      ST_P_KI:   state_next = ST_P_KD;
      ST_P_KD:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_P_ST;
      ST_P_ST:   state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      last_error <= '0;
      error_sum  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SUM) begin
        error_sum  <= sum;
        last_error <= err;
      end
      if (state == ST_OUT && out_free) out_valid <= 1'b1;
      else if (out_ready)              out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        b <= lwf_pkg::range_sat(in_data.side_range_mm);
        a <= lwf_pkg::range_sat(in_data.angled_range_mm);
      end
      ST_M_AS: num <= (p_cw - $signed({{(CW-31){1'b0}}, b, 15'd0})) <<< 8;
      ST_M_LQ: bq <= p_cw;
      ST_ERR: begin
        wall_dist <= wall_dist_next;
        err       <= err_next;
        sum       <= sum_next;
        diff      <= 18'(err_next) - 18'(last_error);
      end
      ST_P_KI: acc <= p[51:0];
      ST_P_KD: acc <= acc + p[51:0];
      ST_SUM:  sneg <= -s_sat;
      ST_OUT: begin
        if (out_free) begin
          out_data.steer_angle      <= steer;
          out_data.speed_mm_s       <= speed;
          out_data.wall_distance_mm <= wall_dist;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // an accepted word always starts the sequence
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_M_AC)
    else $error("accepted word did not start the sequencer");

  // the CORDIC finishes only while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> state == ST_VWAIT || state == ST_RWAIT)
    else $error("CORDIC done outside a wait state");

  // a loaded result carries one of the three speed bands
  a_speed_band: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && out_free |=> out_valid &&
      (out_data.speed_mm_s == lwf_pkg::SPEED_HIGH ||
       out_data.speed_mm_s == lwf_pkg::SPEED_MID ||
       out_data.speed_mm_s == lwf_pkg::SPEED_LOW))
    else $error("result loaded without a valid speed band");

  // a result is only loaded from the last state
  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT)
    else $error("out_valid rose outside the output state");
`endif

endmodule
`default_nettype wire
